/* hdl/euler_to_quaternion_unit_macros.svh */
// Assertion macros shared by the checker of euler_to_quaternion_unit.
// No dependencies.
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define E2Q_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define E2Q_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/e2q_pkg.sv */
// Types and constants for the Euler-to-quaternion converter.
// No dependencies.
package e2q_pkg;

   localparam int AngleWidth  = 16;
   localparam int QuatWidth   = 16;
   localparam int AtanEntries = 24;
   // CORDIC datapath: scale 2^30, values up to about +-2^31, two guard bits
   localparam int CordicWidth = 34;
   localparam int ProdWidth   = 68;

   localparam logic signed [CordicWidth-1:0] GainQ30   = 34'sd652032874;
   localparam logic signed [CordicWidth-1:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic signed [CordicWidth-1:0] PiQ30     = 34'sd3373259426;

   localparam logic signed [QuatWidth-1:0] QuatOne    = 16'sd16384;
   localparam logic signed [QuatWidth-1:0] QuatNegOne = -16'sd16384;

   typedef logic signed [CordicWidth-1:0] cordic_type;

   // cosine and sine of the three half angles
   typedef struct packed {
      cordic_type cr;
      cordic_type sr;
      cordic_type cp;
      cordic_type sp;
      cordic_type cy;
      cordic_type sy;
   } trig_type;

   // arctangent table, atan(2^-i) * 2^30 truncated
   function automatic cordic_type atan_q30(input logic [4:0] idx);
      cordic_type r;
      case (idx)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/e2q_if.sv */
// Valid/ready channel interfaces for the Euler-to-quaternion converter.
// Depends on e2q_pkg.
interface e2q_req_if
   import e2q_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [AngleWidth-1:0]  roll_angle;
   logic signed [AngleWidth-1:0]  pitch_angle;
   logic signed [AngleWidth-1:0]  yaw_angle;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_rsp_if
   import e2q_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [QuatWidth-1:0]  quat_w;
   logic signed [QuatWidth-1:0]  quat_x;
   logic signed [QuatWidth-1:0]  quat_y;
   logic signed [QuatWidth-1:0]  quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* hdl/e2q_cordic.sv */
// Pipelined CORDIC: cosine and sine of half of one Q3.13 angle.
// Depends on e2q_pkg. One register stage for quadrant fold, one per iteration.
module e2q_cordic
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic signed [AngleWidth-1:0] angle,
   output cordic_type                   cos_out,
   output cordic_type                   sin_out
);
   localparam int Iters = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

   cordic_type x_ff [Iters+1];
   cordic_type y_ff [Iters+1];
   cordic_type z_ff [Iters+1];
   logic       flip_ff [Iters+1];

   cordic_type ang;
   cordic_type ang_in;
   logic       flip_in;

   // halve angle to scale 2^30 and fold into [-pi/2, pi/2]
   always_comb begin
      ang = {{(CordicWidth-AngleWidth-16){angle[AngleWidth-1]}}, angle, 16'd0};
      ang_in = ang;
      flip_in = 1'b0;
      if (ang > HalfPiQ30) begin
         ang_in = ang - PiQ30;
         flip_in = 1'b1;
      end else if (ang < -HalfPiQ30) begin
         ang_in = ang + PiQ30;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= GainQ30;
         y_ff[0] <= '0;
         z_ff[0] <= ang_in;
         flip_ff[0] <= flip_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < Iters; i++) begin : g_iter
      cordic_type dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][CordicWidth-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q30(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q30(5'(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign cos_out = flip_ff[Iters] ? -x_ff[Iters] : x_ff[Iters];
   assign sin_out = flip_ff[Iters] ? -y_ff[Iters] : y_ff[Iters];
endmodule

/* hdl/e2q_combine.sv */
// Triple products and quaternion assembly, four register stages.
// Depends on e2q_pkg.
module e2q_combine
   import e2q_pkg::*;
(
   input  logic                        clock,
   input  logic                        advance,
   input  trig_type                    trig,
   output logic signed [QuatWidth-1:0] quat_out [4]
);
   localparam int PairWidth = CordicWidth * 2;
   // floored pair stays below 2^31 in magnitude, so the CORDIC width holds it
   localparam int Q30Width  = CordicWidth;

   typedef logic signed [PairWidth-1:0] pair_type;
   typedef logic signed [ProdWidth-1:0] prod_type;

   // first factor pairs: cr*cp, sr*sp, sr*cp, cr*sp
   pair_type ab_ff [4];
   cordic_type cy_ff, sy_ff;
   // triple products, two per component
   prod_type t_ff [8];
   logic signed [ProdWidth:0] sum_ff [4];
   logic signed [QuatWidth-1:0] q_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         ab_ff[0] <= trig.cr * trig.cp;
         ab_ff[1] <= trig.sr * trig.sp;
         ab_ff[2] <= trig.sr * trig.cp;
         ab_ff[3] <= trig.cr * trig.sp;
         cy_ff <= trig.cy;
         sy_ff <= trig.sy;
      end
   end

   // floor by 2^30, multiply by the yaw term
   logic signed [Q30Width-1:0] f [4];
   for (genvar k = 0; k < 4; k++) begin : g_floor
      assign f[k] = ab_ff[k][30+Q30Width-1:30];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[0] <= ProdWidth'(f[0] * cy_ff);   // cr cp cy
         t_ff[1] <= ProdWidth'(f[1] * sy_ff);   // sr sp sy
         t_ff[2] <= ProdWidth'(f[2] * cy_ff);   // sr cp cy
         t_ff[3] <= ProdWidth'(f[3] * sy_ff);   // cr sp sy
         t_ff[4] <= ProdWidth'(f[3] * cy_ff);   // cr sp cy
         t_ff[5] <= ProdWidth'(f[2] * sy_ff);   // sr cp sy
         t_ff[6] <= ProdWidth'(f[0] * sy_ff);   // cr cp sy
         t_ff[7] <= ProdWidth'(f[1] * cy_ff);   // sr sp cy
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff[0] <= {t_ff[0][ProdWidth-1], t_ff[0]} + {t_ff[1][ProdWidth-1], t_ff[1]};
         sum_ff[1] <= {t_ff[2][ProdWidth-1], t_ff[2]} - {t_ff[3][ProdWidth-1], t_ff[3]};
         sum_ff[2] <= {t_ff[4][ProdWidth-1], t_ff[4]} + {t_ff[5][ProdWidth-1], t_ff[5]};
         sum_ff[3] <= {t_ff[6][ProdWidth-1], t_ff[6]} - {t_ff[7][ProdWidth-1], t_ff[7]};
      end
   end

   // round half up to Q2.14 and saturate
   for (genvar k = 0; k < 4; k++) begin : g_round
      logic signed [ProdWidth:0]    rnd;
      logic signed [ProdWidth-46:0] r;
      assign rnd = sum_ff[k] + (ProdWidth+1)'(64'sd1 <<< 45);
      assign r   = rnd[ProdWidth:46];
      always_ff @(posedge clock) begin
         if (advance) begin
            if (r > (ProdWidth-45)'(QuatOne))
               q_ff[k] <= QuatOne;
            else if (r < (ProdWidth-45)'(QuatNegOne))
               q_ff[k] <= QuatNegOne;
            else
               q_ff[k] <= r[QuatWidth-1:0];
         end
      end
      assign quat_out[k] = q_ff[k];
   end
endmodule

/* hdl/euler_to_quaternion_unit.sv */
// Euler angles (ZYX) to unit quaternion. One transaction per cycle is
// accepted while the pipeline advances; each result passes through one
// fold stage, one stage per CORDIC iteration and four product stages.
// The whole pipeline advances together and holds when the output
// register is full and not taken.
// Depends on e2q_pkg, e2q_if, e2q_cordic and e2q_combine.
module euler_to_quaternion_unit
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input logic        clock,
   input logic        reset,
   e2q_req_if.sink    req,
   e2q_rsp_if.source  rsp
);
   localparam int Iters = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
   localparam int Depth = Iters + 5;

   logic [Depth-1:0] valid_ff, valid_in;
   logic             advance;
   trig_type         trig;
   logic signed [QuatWidth-1:0] quat [4];

   // pipeline moves when the last stage is empty or is being taken
   assign advance   = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = {valid_ff[Depth-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock, .advance, .angle(req.roll_angle), .cos_out(trig.cr), .sin_out(trig.sr));
   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock, .advance, .angle(req.pitch_angle), .cos_out(trig.cp), .sin_out(trig.sp));
   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock, .advance, .angle(req.yaw_angle), .cos_out(trig.cy), .sin_out(trig.sy));

   e2q_combine u_combine (.clock, .advance, .trig, .quat_out(quat));

   assign rsp.valid  = valid_ff[Depth-1];
   assign rsp.quat_w = quat[0];
   assign rsp.quat_x = quat[1];
   assign rsp.quat_y = quat[2];
   assign rsp.quat_z = quat[3];
endmodule

/* hdl/e2q_checker.sv */
// Port-level checker for euler_to_quaternion_unit, with its bind.
// Depends on e2q_pkg and euler_to_quaternion_unit_macros.svh.
`include "euler_to_quaternion_unit_macros.svh"
module e2q_checker
   import e2q_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [QuatWidth-1:0] quat_w,
   input logic signed [QuatWidth-1:0] quat_x
);
   `E2Q_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "stall with empty output")
   `E2Q_ASSERT_IMPL(a_w_range, clock, reset, rsp_valid, quat_w <= QuatOne && quat_w >= QuatNegOne, "quat_w out of range")
   `E2Q_ASSERT_IMPL(a_x_range, clock, reset, rsp_valid, quat_x <= QuatOne && quat_x >= QuatNegOne, "quat_x out of range")
   `E2Q_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(quat_w), "stalled result changed")
endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .quat_w(rsp.quat_w), .quat_x(rsp.quat_x)
);
